>>> design/sabs_pkg.sv
// shared constants, codes and structs of the sentence-aligned block splitter
package sabs_pkg;

  localparam int MAX_BLOCKS = 256;
  localparam int ROW_BITS   = 32;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = 9;
  localparam int IDX_BITS   = 8;
  localparam int SUM_BITS   = CNT_BITS + 2;
  localparam int DIV_BITS   = ROW_BITS + CNT_BITS;
  localparam int STEP_BITS  = $clog2(DIV_BITS + 1);
  localparam int CFG_BITS   = 32;
  localparam int REG_BITS   = 2;

  // register indexes
  localparam logic [REG_BITS-1:0] REG_BLOCK_COUNT = 2'd0;
  localparam logic [REG_BITS-1:0] REG_TOTAL_ROWS  = 2'd1;
  localparam logic [REG_BITS-1:0] REG_SEPARATOR   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_AVG   = 2'd1;
  localparam logic [1:0] ERR_FEW   = 2'd2;
  localparam logic [1:0] ERR_SPLIT = 2'd3;

  typedef struct packed {
    logic [IDX_BITS-1:0] idx;
    logic [ROW_BITS-1:0] start;
    logic [ROW_BITS-1:0] len;
    logic [1:0]          err;
    logic                fin;
  } res_t;

  typedef struct packed {
    logic latch_row;
    logic div_first;
    logic div_next;
    logic load_target_first;
    logic load_target;
    logic cut_step;
    logic final_step;
    logic load_err;
    logic clear_held;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic       held_valid;
    logic       finished;
    logic       err_avg;
    logic       past_end;
    logic       row_zero;
    logic       div_done;
    logic [1:0] fin_cnt;
    logic       fin_need_div;
  } dp_stat_t;

endpackage

>>> design/sabs_div.sv
// restoring divider, one quotient bit per cycle
module sabs_div import sabs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [CNT_BITS-1:0] divisor,
  output logic                busy,
  output logic                done,
  output logic [ROW_BITS-1:0] quotient
);

  logic [CNT_BITS-1:0]  acc;
  logic [DIV_BITS-1:0]  quo;
  logic [CNT_BITS-1:0]  dsr;
  logic [STEP_BITS-1:0] steps;
  logic [CNT_BITS:0]    trial;
  logic                 ge;

  assign trial = {acc, quo[DIV_BITS-1]};
  assign ge    = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(DIV_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      acc <= ge ? CNT_BITS'(trial - {1'b0, dsr}) : trial[CNT_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], ge};
    end
  end

  assign quotient = quo[ROW_BITS-1:0];

  start_when_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");

endmodule

>>> design/sabs_dp.sv
// datapath: config, split state, cut and closing logic, result slots, divider
module sabs_dp import sabs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  input  logic [WORD_BITS-1:0] row_value,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  output logic [IDX_BITS-1:0]  block_index,
  output logic [ROW_BITS-1:0]  block_start,
  output logic [ROW_BITS-1:0]  block_length,
  output logic [1:0]           error_code,
  output logic                 final_block
);

  // config
  logic [CNT_BITS-1:0]  block_count;
  logic [ROW_BITS-1:0]  total_rows;
  logic [WORD_BITS-1:0] separator_value;

  // split state
  logic [WORD_BITS-1:0] row_word;
  logic [ROW_BITS-1:0]  row_index;
  logic [CNT_BITS-1:0]  blocks_done;
  logic [ROW_BITS-1:0]  target_row;
  logic [ROW_BITS-1:0]  cur_start;
  logic [ROW_BITS-1:0]  sent_start;
  logic                 finished;
  logic                 held_valid;
  logic                 cut_flag;
  res_t                 res_cut;
  res_t                 res0, res1, res2;

  logic [CNT_BITS-1:0]  n_eff;
  logic [SUM_BITS-1:0]  n_x, bd_x;
  logic [ROW_BITS:0]    two_n;
  logic [ROW_BITS-1:0]  i_plus;
  logic                 sep_hit, at_target, near_end, take_after;
  logic [ROW_BITS-1:0]  cut;
  logic                 is_last, f_one, f_split;
  res_t                 r_a, r_b;
  logic [1:0]           nf;
  logic [CNT_BITS-1:0]  bd_inc;
  logic                 use_rest;
  logic [DIV_BITS-1:0]  div_dividend;
  logic [CNT_BITS-1:0]  div_divisor;
  logic                 div_busy, div_done;
  logic [ROW_BITS-1:0]  div_quo;

  always_comb begin
    n_eff = block_count;
    if (block_count == '0) n_eff = CNT_BITS'(1);
    if (block_count > CNT_BITS'(MAX_BLOCKS)) n_eff = CNT_BITS'(MAX_BLOCKS);
  end

  assign n_x    = SUM_BITS'(n_eff);
  assign bd_x   = SUM_BITS'(blocks_done);
  assign two_n  = (ROW_BITS + 1)'(n_eff) << 1;
  assign i_plus = row_index + 1'b1;
  assign bd_inc = blocks_done + 1'b1;

  // cut step
  assign sep_hit    = (bd_x + 1'b1 < n_x) && (row_word == separator_value);
  assign at_target  = row_index >= target_row;
  assign near_end   = (sent_start < target_row) &&
                      ((row_index - target_row) < (target_row - sent_start));
  assign take_after = near_end || (sent_start < cur_start);
  assign cut        = take_after ? i_plus : sent_start;

  // closing step at the last row
  assign is_last = ((ROW_BITS + 1)'(row_index) + 1'b1) == (ROW_BITS + 1)'(total_rows);
  assign f_one   = (bd_x + 1'b1) == n_x;
  assign f_split = (bd_x + 2'd2 == n_x) && !(sent_start < cur_start);

  always_comb begin
    r_a = '{idx: blocks_done[IDX_BITS-1:0], start: '0, len: '0, err: ERR_NONE, fin: 1'b0};
    r_b = '{idx: bd_inc[IDX_BITS-1:0], start: sent_start,
            len: total_rows - sent_start, err: ERR_NONE, fin: 1'b1};
    nf  = 2'd0;
    if (is_last) begin
      if (f_one) begin
        r_a.start = cur_start;
        r_a.len   = total_rows - cur_start;
        r_a.fin   = 1'b1;
        nf        = 2'd1;
      end else if (bd_x + 1'b1 < n_x) begin
        nf = 2'd1;
        if (bd_x + 2'd2 < n_x) begin
          r_a.err = ERR_FEW;
        end else if (sent_start < cur_start) begin
          r_a.err = ERR_SPLIT;
        end else begin
          r_a.start = cur_start;
          r_a.len   = sent_start - cur_start;
          nf        = 2'd2;
        end
      end
    end
  end

  // next target: total over block count at row 0, rest over remaining blocks near the end, else scaled share
  assign use_rest = bd_x + 2'd3 > n_x;
  always_comb begin
    if (cmd.div_first) begin
      div_dividend = DIV_BITS'(total_rows);
      div_divisor  = n_eff;
    end else if (use_rest) begin
      div_dividend = DIV_BITS'(total_rows - cur_start);
      div_divisor  = n_eff - blocks_done;
    end else begin
      div_dividend = DIV_BITS'(total_rows) * DIV_BITS'(bd_inc);
      div_divisor  = n_eff;
    end
  end

  sabs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_first || cmd.div_next),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count     <= CNT_BITS'(1);
      total_rows      <= '0;
      separator_value <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_COUNT: block_count     <= cfg_data[CNT_BITS-1:0];
        REG_TOTAL_ROWS:  total_rows      <= cfg_data[ROW_BITS-1:0];
        REG_SEPARATOR:   separator_value <= cfg_data[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_index   <= '0;
      blocks_done <= '0;
      target_row  <= '0;
      cur_start   <= '0;
      sent_start  <= '0;
      finished    <= 1'b0;
      held_valid  <= 1'b0;
      cut_flag    <= 1'b0;
    end else begin
      if (cmd.clear_held) held_valid <= 1'b0;
      if (cmd.load_err) finished <= 1'b1;
      if (cmd.load_target) target_row <= div_quo;
      if (cmd.load_target_first) begin
        target_row  <= div_quo;
        blocks_done <= '0;
        cur_start   <= '0;
        sent_start  <= '0;
      end
      if (cmd.cut_step) begin
        cut_flag <= 1'b0;
        if (sep_hit && at_target) begin
          cut_flag    <= 1'b1;
          blocks_done <= bd_inc;
          cur_start   <= cut;
          if (!take_after) sent_start <= i_plus;
        end else if (sep_hit) begin
          sent_start <= i_plus;
        end
      end
      if (cmd.final_step) begin
        row_index <= i_plus;
        if (is_last) begin
          finished <= 1'b1;
          if (f_one) begin
            blocks_done <= bd_inc;
          end else if (f_split) begin
            blocks_done <= blocks_done + 2'd2;
            cur_start   <= sent_start;
          end
        end
        held_valid <= cut_flag && (nf == 2'd2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_row) row_word <= row_value;
    if (cmd.cut_step) begin
      res_cut <= '{idx: blocks_done[IDX_BITS-1:0], start: cur_start,
                   len: cut - cur_start, err: ERR_NONE, fin: 1'b0};
    end
    if (cmd.load_err) begin
      res0 <= '{idx: blocks_done[IDX_BITS-1:0], start: '0, len: '0,
                err: ERR_AVG, fin: 1'b0};
    end else if (cmd.final_step) begin
      res0 <= cut_flag ? res_cut : r_a;
      res1 <= cut_flag ? r_a : r_b;
      res2 <= r_b;
    end else if (cmd.pop) begin
      res0 <= res1;
      res1 <= res2;
    end
  end

  always_comb begin
    stat.held_valid   = held_valid;
    stat.finished     = finished;
    stat.err_avg      = (n_eff > CNT_BITS'(1)) && ((ROW_BITS + 1)'(total_rows) < two_n);
    stat.past_end     = row_index >= total_rows;
    stat.row_zero     = row_index == '0;
    stat.div_done     = div_done;
    stat.fin_cnt      = 2'(cut_flag) + nf;
    stat.fin_need_div = cut_flag && !is_last;
  end

  assign block_index  = res0.idx;
  assign block_start  = res0.start;
  assign block_length = res0.len;
  assign error_code   = res0.err;
  assign final_block  = res0.fin;

  held_only_when_finished: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> finished)
    else $error("held word without a finished split");
  no_step_while_dividing: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> !(cmd.cut_step || cmd.final_step))
    else $error("split state stepped while target is being divided");

endmodule

>>> design/sabs_ctrl.sv
// controller state machine sequencing accept, cut, close, output and divide
module sabs_ctrl import sabs_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     row_valid,
  output logic     row_ready,
  output logic     result_valid,
  input  logic     result_ready,
  output logic     last_result,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PREP   = 8'b0000_0010,
    S_DWAIT0 = 8'b0000_0100,
    S_CUT    = 8'b0000_1000,
    S_FINAL  = 8'b0001_0000,
    S_OUT    = 8'b0010_0000,
    S_DSTART = 8'b0100_0000,
    S_DWAIT  = 8'b1000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] rem, rem_next;
  logic       div_pend, div_pend_next;

  assign row_ready    = state == S_IDLE;
  assign result_valid = state == S_OUT;
  assign last_result  = rem == 2'd1;

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    div_pend_next = div_pend;
    cmd           = '0;
    cmd.latch_row = row_valid && row_ready;
    cmd.pop       = result_valid && result_ready;
    case (state)
      S_IDLE: begin
        if (row_valid) state_next = S_PREP;
      end
      S_PREP: begin
        div_pend_next = 1'b0;
        if (stat.held_valid) begin
          cmd.clear_held = 1'b1;
          rem_next       = 2'd1;
          state_next     = S_OUT;
        end else if (stat.finished) begin
          state_next = S_IDLE;
        end else if (stat.err_avg) begin
          cmd.load_err = 1'b1;
          rem_next     = 2'd1;
          state_next   = S_OUT;
        end else if (stat.past_end) begin
          state_next = S_IDLE;
        end else if (stat.row_zero) begin
          cmd.div_first = 1'b1;
          state_next    = S_DWAIT0;
        end else begin
          state_next = S_CUT;
        end
      end
      S_DWAIT0: begin
        if (stat.div_done) begin
          cmd.load_target_first = 1'b1;
          state_next            = S_CUT;
        end
      end
      S_CUT: begin
        cmd.cut_step = 1'b1;
        state_next   = S_FINAL;
      end
      S_FINAL: begin
        cmd.final_step = 1'b1;
        div_pend_next  = stat.fin_need_div;
        rem_next       = (stat.fin_cnt > 2'd2) ? 2'd2 : stat.fin_cnt;
        if (stat.fin_cnt != 2'd0) state_next = S_OUT;
        else if (stat.fin_need_div) state_next = S_DSTART;
        else state_next = S_IDLE;
      end
      S_OUT: begin
        if (result_ready) begin
          rem_next = rem - 1'b1;
          if (rem == 2'd1) state_next = div_pend ? S_DSTART : S_IDLE;
        end
      end
      S_DSTART: begin
        cmd.div_next = 1'b1;
        state_next   = S_DWAIT;
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.load_target = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rem      <= '0;
      div_pend <= 1'b0;
    end else begin
      state    <= state_next;
      rem      <= rem_next;
      div_pend <= div_pend_next;
    end
  end

  out_has_words: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) |-> (rem != 2'd0))
    else $error("output state with no word left to send");
  out_leads_on: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && result_ready && rem == 2'd1) |=>
      (state == S_IDLE || state == S_DSTART))
    else $error("last word sent but controller did not move on");

endmodule

>>> design/sentence_aligned_block_splitter.sv
// top level of the sentence-aligned block splitter
// a row goes from accept through the prep, cut and close states, then the output state
//   (held until result_ready) for each result word, back to idle; each result word sits
//   in an output register; row 0 and every cut before the last row also run the iterative
//   target divider (one quotient bit per cycle over a 41-bit dividend), with a handoff
//   through S_DWAIT0 at row 0 and through S_DSTART and S_DWAIT after a cut
// one row at a time: a new row is accepted only in the idle state
// reset (rst, synchronous): block_count = 1, other config and split positions, counts, flags 0
module sentence_aligned_block_splitter import sabs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [REG_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]  cfg_data,
  // row input channel
  input  logic                 row_valid,
  output logic                 row_ready,
  input  logic [WORD_BITS-1:0] row_value,
  // block result channel
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [IDX_BITS-1:0]  block_index,
  output logic [ROW_BITS-1:0]  block_start,
  output logic [ROW_BITS-1:0]  block_length,
  output logic [1:0]           error_code,
  output logic                 final_block,
  output logic                 last_result
);

  // command and status between the controller and the datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // controller: handshakes, sequencing of each row, output word count
  sabs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .row_valid    (row_valid),
    .row_ready    (row_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .last_result  (last_result),
    .stat         (stat),
    .cmd          (cmd)
  );

  // datapath: config registers, split state, result slots, target divider
  sabs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_value    (row_value),
    .cmd          (cmd),
    .stat         (stat),
    .block_index  (block_index),
    .block_start  (block_start),
    .block_length (block_length),
    .error_code   (error_code),
    .final_block  (final_block)
  );

endmodule

>>> bench/sentence_aligned_block_splitter_tb.sv
// self-checking testbench of the sentence-aligned block splitter, with its own block predictor
module sentence_aligned_block_splitter_tb;
  import sabs_pkg::*;

  // cycles the block may still be busy after the last result word
  // (row pipeline plus one full target division and handoff)
  localparam int SETTLE_CYCLES = 120;
  localparam int CHUNKS        = 8;

  // one expected result word: the block's payload plus the last-word flag
  typedef struct packed {
    res_t body;
    logic last;
  } block_report_t;

  // what to change between chunks of the mixed stream
  typedef enum int {
    RESHAPE_KEEP, RESHAPE_SEPARATOR, RESHAPE_COUNT, RESHAPE_PAST_END, RESHAPE_HUGE_TOTAL
  } reshape_t;

  // how the stream is brought to its end
  typedef enum int {
    END_AVERAGE, END_TOO_FEW, END_CLOSE, END_BACKTRACK, END_CUT_AND_SPLIT
  } stream_end_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [REG_BITS-1:0]  cfg_index = REG_BLOCK_COUNT;
  logic [CFG_BITS-1:0]  cfg_data = '0;
  logic                 row_valid = 1'b0;
  logic                 row_ready;
  logic [WORD_BITS-1:0] row_value = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [IDX_BITS-1:0]  block_index;
  logic [ROW_BITS-1:0]  block_start;
  logic [ROW_BITS-1:0]  block_length;
  logic [1:0]           error_code;
  logic                 final_block;
  logic                 last_result;

  sentence_aligned_block_splitter DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .row_valid    (row_valid),
    .row_ready    (row_ready),
    .row_value    (row_value),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .block_index  (block_index),
    .block_start  (block_start),
    .block_length (block_length),
    .error_code   (error_code),
    .final_block  (final_block),
    .last_result  (last_result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor copy of the registers, as they stand after reset
  logic [8:0]           cfg_count = 9'd1;
  logic [ROW_BITS-1:0]  cfg_rows  = '0;
  logic [WORD_BITS-1:0] cfg_sep   = '0;

  // predictor copy of the split state
  logic [ROW_BITS-1:0]  row_pos       = '0;  // index of the next row
  logic [8:0]           cut_count     = '0;  // blocks closed so far
  logic [ROW_BITS-1:0]  target        = '0;  // row at which the next cut may fall
  logic [ROW_BITS-1:0]  block_base    = '0;  // first row of the open block
  logic [ROW_BITS-1:0]  sentence_base = '0;  // first row after the last separator
  bit                   split_done    = 1'b0;
  bit                   held_valid    = 1'b0;
  block_report_t        held_report;

  block_report_t blocks_due[$];        // result words still to come, oldest first
  int            blocks_predicted = 0; // good blocks forecast so far
  int            mismatch_count   = 0;
  logic [ROW_BITS-1:0] main_total;     // stream length used while rows flow

  // stimulus knobs
  int src_rate   = 0;   // 0: sender never idles, 3: idles often
  bit quiet_tail = 1'b0; // no idling on either side in the last part
  int sink_hold  = 0;
  int sink_rate  = 0;
  int sink_ticks = 0;

  function automatic block_report_t make_report(input longint unsigned idx, start, len,
                                                input logic [1:0] err, input logic fin);
    block_report_t r;
    r.body.idx   = idx[IDX_BITS-1:0];
    r.body.start = start[ROW_BITS-1:0];
    r.body.len   = len[ROW_BITS-1:0];
    r.body.err   = err;
    r.body.fin   = fin;
    r.last       = 1'b0;
    return r;
  endfunction

  // forecast the result words that one accepted row causes and queue them
  function automatic void forecast_blocks(input logic [WORD_BITS-1:0] word);
    block_report_t made[$];
    longint unsigned n, total, i, b, cut;
    bit near_end;
    // a third word left over from the stream end goes out on the next row, whatever it is
    if (held_valid) begin
      held_report.last = 1'b1;
      blocks_due.push_back(held_report);
      held_valid = 1'b0;
      return;
    end
    if (split_done) return;
    n = cfg_count;
    if (n == 0) n = 1;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    total = cfg_rows;
    if (n > 1 && total < 2 * n) begin
      // fewer than two rows per block on average
      made.push_back(make_report(cut_count, 0, 0, ERR_AVG, 1'b0));
      split_done = 1'b1;
    end else if (row_pos < total) begin
      i = row_pos;
      if (i == 0) begin
        target        = ROW_BITS'(total / n);
        cut_count     = '0;
        block_base    = '0;
        sentence_base = '0;
      end
      if (cut_count + 1 < n && word == cfg_sep) begin
        if (i >= target) begin
          // cut after this row or at the previous sentence end, whichever is nearer (sentence end on a tie)
          near_end = sentence_base < target && (i - target) < (target - sentence_base);
          if (near_end || sentence_base < block_base) begin
            cut = i + 1;
          end else begin
            cut = sentence_base;
            sentence_base = ROW_BITS'(i + 1);
          end
          made.push_back(make_report(cut_count, block_base, cut - block_base, ERR_NONE, 1'b0));
          cut_count  = 9'(cut_count + 1);
          block_base = ROW_BITS'(cut);
          if (cut_count < n) begin
            if (cut_count + 3 > n) target = ROW_BITS'((total - cut) / (n - cut_count));
            else target = ROW_BITS'((total * (cut_count + 1)) / n);
          end
        end else begin
          sentence_base = ROW_BITS'(i + 1);
        end
      end
      if (i + 1 == total) begin
        b = cut_count;
        split_done = 1'b1;
        if (b + 1 == n) begin
          made.push_back(make_report(b, block_base, total - block_base, ERR_NONE, 1'b1));
          cut_count = 9'(b + 1);
        end else if (b + 1 < n) begin
          if (b + 2 < n) begin
            made.push_back(make_report(b, 0, 0, ERR_FEW, 1'b0));
          end else if (sentence_base < block_base) begin
            made.push_back(make_report(b, 0, 0, ERR_SPLIT, 1'b0));
          end else begin
            // one block short: split the open block at the last sentence start
            made.push_back(make_report(b, block_base, sentence_base - block_base, ERR_NONE,
                                       1'b0));
            made.push_back(make_report(b + 1, sentence_base, total - sentence_base, ERR_NONE,
                                       1'b1));
            block_base = sentence_base;
            cut_count  = 9'(b + 2);
          end
        end
      end
      row_pos = ROW_BITS'(i + 1);
    end
    if (made.size() > 2) begin
      held_report = made.pop_back();
      held_valid  = 1'b1;
    end
    if (made.size() > 0) made[made.size() - 1].last = 1'b1;
    foreach (made[k]) begin
      if (made[k].body.err == ERR_NONE) blocks_predicted++;
      blocks_due.push_back(made[k]);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // block_count write with random bits above the 9 that count
  function automatic logic [CFG_BITS-1:0] count_word(input int n);
    logic [CFG_BITS-1:0] w;
    w = $urandom;
    w[8:0] = n[8:0];
    return w;
  endfunction

  function automatic logic [WORD_BITS-1:0] other_row();
    logic [WORD_BITS-1:0] w;
    do w = $urandom; while (w == cfg_sep);
    return w;
  endfunction

  // separators, near misses one bit off, and plain words
  function automatic logic [WORD_BITS-1:0] pick_row();
    int roll;
    roll = $urandom_range(0, 15);
    if (roll < 2) return cfg_sep;
    if (roll < 4) return cfg_sep ^ (32'h1 << $urandom_range(0, WORD_BITS - 1));
    return other_row();
  endfunction

  // write all three registers back to back; enable stays high across the writes
  task automatic program_split(input logic [CFG_BITS-1:0] count_w, rows_w, sep_w);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= count_w;
    @(posedge clk);
    cfg_count = count_w[8:0];
    cfg_index <= REG_TOTAL_ROWS;
    cfg_data  <= rows_w;
    @(posedge clk);
    cfg_rows = rows_w;
    cfg_index <= REG_SEPARATOR;
    cfg_data  <= sep_w;
    @(posedge clk);
    cfg_sep = sep_w;
    cfg_we <= 1'b0;
  endtask

  // offer one row word, wait for its handshake, then maybe idle for a burst
  task automatic send_row(input logic [WORD_BITS-1:0] word);
    int gap;
    row_valid <= 1'b1;
    row_value <= word;
    @(posedge clk);
    while (!row_ready) @(posedge clk);
    forecast_blocks(word);
    if (!quiet_tail && src_rate != 0 && $urandom_range(0, 7) < src_rate) begin
      gap = $urandom_range(1, 12);
      row_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drain every expected word, then give a row that causes none time to finish
  task automatic wait_idle();
    row_valid <= 1'b0;
    while (blocks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // zero rows in the stream and block_count 0: every row lies beyond the end
  task automatic test_empty_stream();
    program_split(count_word(0), '0, '1);
    send_row('0);
    send_row('1);
    send_row($urandom);
  endtask

  // start of the real stream with 511 blocks requested (256 used), so cuts come early
  task automatic test_opening_rows();
    logic [WORD_BITS-1:0] sep;
    int first_target;
    wait_idle();
    do sep = $urandom; while (sep == '0 || sep == '1);
    main_total = $urandom_range(3300, 4000);
    program_split(count_word(511), main_total, sep);
    first_target = main_total / MAX_BLOCKS;
    src_rate = 1;
    for (int k = 0; k < 22; k++) begin
      if (k == 0) send_row('0);
      else if (k == 1) send_row('1);
      else if (k == 2 || k == 4 || k == 20) send_row(sep);
      else if (k == 3) send_row(sep ^ 32'h1);
      else if (k == 5) send_row(sep ^ 32'h8000_0000);
      else if (k == first_target || k == first_target + 3) send_row(sep);
      else send_row(other_row());
    end
  endtask

  // long stream in chunks; registers change between chunks while the block is idle
  task automatic test_mixed_stream();
    reshape_t how;
    int chunk;
    chunk = 0;
    while (chunk < CHUNKS || (blocks_predicted < 40 && chunk < CHUNKS + 3)) begin
      wait_idle();
      how = reshape_t'($urandom_range(0, 4));
      case (how)
        RESHAPE_SEPARATOR: begin
          case ($urandom_range(0, 2))
            0: program_split(count_word(cfg_count), main_total, '0);
            1: program_split(count_word(cfg_count), main_total, '1);
            default: program_split(count_word(cfg_count), main_total, $urandom);
          endcase
        end
        RESHAPE_COUNT: begin
          case ($urandom_range(0, 3))
            0: program_split(count_word(1), main_total, cfg_sep);
            1: program_split(count_word(511), main_total, cfg_sep);
            2: program_split(count_word($urandom_range(128, MAX_BLOCKS)), main_total, cfg_sep);
            default: program_split(count_word($urandom_range(2, 64)), main_total, cfg_sep);
          endcase
        end
        RESHAPE_PAST_END: begin
          // stream cut short at the current row: rows are dropped, none advance
          if (row_pos >= 2 * MAX_BLOCKS) begin
            program_split(count_word(cfg_count), row_pos, cfg_sep);
            repeat ($urandom_range(3, 8)) send_row(pick_row());
            wait_idle();
            program_split(count_word(cfg_count), main_total, cfg_sep);
          end
        end
        RESHAPE_HUGE_TOTAL: begin
          // largest row count; no separators, so the pending target stays as it is
          program_split(count_word(cfg_count), '1, cfg_sep);
          repeat ($urandom_range(10, 25)) send_row(other_row());
          wait_idle();
          program_split(count_word(cfg_count), main_total, cfg_sep);
        end
        default: ;
      endcase
      src_rate = $urandom_range(0, 3);
      repeat ($urandom_range(200, 240)) send_row(pick_row());
      chunk++;
    end
  endtask

  // bring the stream to one of its endings, then feed rows the block ignores
  task automatic test_stream_end();
    stream_end_t how;
    int count;
    longint unsigned last_pos;
    wait_idle();
    quiet_tail = 1'b1;
    how = stream_end_t'($urandom_range(0, 4));
    last_pos = row_pos;
    case (how)
      END_AVERAGE: begin
        count = $urandom_range(2, MAX_BLOCKS);
        program_split(count_word(count), $urandom_range(0, 2 * count - 1), cfg_sep);
      end
      END_TOO_FEW:
        program_split(count_word(cut_count + $urandom_range(3, 7)),
                      row_pos + $urandom_range(1, 4), cfg_sep);
      END_CLOSE:
        program_split(count_word(cut_count + 1), row_pos + $urandom_range(1, 4), cfg_sep);
      END_BACKTRACK:
        program_split(count_word(cut_count + 2), row_pos + $urandom_range(1, 4), cfg_sep);
      default: begin
        // last row is a separator at or past the target: a cut, then the split
        if (target > row_pos && target - row_pos < 300) last_pos = target;
        program_split(count_word(cut_count + 3),
                      ROW_BITS'(last_pos + $urandom_range(1, 3)), cfg_sep);
      end
    endcase
    while (!split_done || held_valid) begin
      if (how == END_CUT_AND_SPLIT && row_pos + 1 == cfg_rows) send_row(cfg_sep);
      else if (how == END_CLOSE) send_row(pick_row());
      else send_row(other_row());
    end
    repeat (2) send_row(pick_row());
  endtask

  // result side stalls in bursts; the stall rate drifts, and is sometimes zero
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      sink_ticks++;
      if (sink_ticks % 256 == 0) sink_rate = $urandom_range(0, 3);
      if (sink_hold > 0) sink_hold--;
      else if (!quiet_tail && sink_rate != 0 && $urandom_range(0, 15) < sink_rate)
        sink_hold = $urandom_range(1, 12);
      result_ready <= (sink_hold == 0) || quiet_tail;
    end
  end

  // every accepted result word against the oldest forecast
  always @(posedge clk) begin
    block_report_t want;
    if (!rst && result_valid && result_ready) begin
      if (blocks_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word: block %0d start %0d length %0d err %0d",
                                  block_index, block_start, block_length, error_code));
      end else begin
        want = blocks_due.pop_front();
        if (block_index !== want.body.idx)
          report_mismatch($sformatf("block_index %0d, want %0d", block_index, want.body.idx));
        if (block_start !== want.body.start)
          report_mismatch($sformatf("block_start %0d, want %0d", block_start, want.body.start));
        if (block_length !== want.body.len)
          report_mismatch($sformatf("block_length %0d, want %0d", block_length, want.body.len));
        if (error_code !== want.body.err)
          report_mismatch($sformatf("error_code %0d, want %0d", error_code, want.body.err));
        if (final_block !== want.body.fin)
          report_mismatch($sformatf("final_block %0b, want %0b", final_block, want.body.fin));
        if (last_result !== want.last)
          report_mismatch($sformatf("last_result %0b, want %0b", last_result, want.last));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_stream();
    test_opening_rows();
    test_mixed_stream();
    test_stream_end();
    wait_idle();
    if (blocks_due.size() != 0) report_mismatch("result words still outstanding");
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hard stop far beyond the slowest good run
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
design/sabs_pkg.sv
design/sabs_div.sv
design/sabs_dp.sv
design/sabs_ctrl.sv
design/sentence_aligned_block_splitter.sv
bench/sentence_aligned_block_splitter_tb.sv
